// ===== src/lmsr_pkg.sv =====
// Shared types and constants for the LED matrix chain scroll and refresh block.
`default_nettype none

package lmsr_pkg;

    // Command codes carried in the opcode field.
    typedef enum logic [2:0] {
        OP_CLEAR_STORE = 3'd0,
        OP_PUSH        = 3'd1,
        OP_SCROLL      = 3'd2,
        OP_REFRESH     = 3'd3,
        OP_INIT        = 3'd4,
        OP_CLEAR_DISP  = 3'd5
    } t_op;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROT_RD,
        ST_ROT_WR,
        ST_REF_RD,
        ST_REF_EMIT,
        ST_INIT,
        ST_CLR_DISP
    } t_state;

    // Driver register addresses and fixed data bytes.
    localparam logic [3:0] ADDR_INTENSITY  = 4'h0A;
    localparam logic [3:0] ADDR_SCAN_LIMIT = 4'h0B;
    localparam logic [3:0] ADDR_SHUTDOWN   = 4'h0C;
    localparam logic [7:0] SHUTDOWN_NORMAL = 8'h01;
    localparam logic [7:0] ZERO_DATA       = 8'h00;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INTENSITY  = 2'd0;
    localparam logic [1:0] CFG_SCAN_LIMIT = 2'd1;

    // One command word.
    typedef struct packed {
        logic [2:0] opcode;
        logic [7:0] push_byte;
    } t_cmd;

    // One driver register write.
    typedef struct packed {
        logic       broadcast;
        logic [2:0] device_slot;
        logic [3:0] reg_address;
        logic [7:0] reg_data;
        logic       last;
    } t_wr;

    // Live configuration values.
    typedef struct packed {
        logic [3:0] intensity_level;
        logic [2:0] scan_limit;
    } t_cfg;

endpackage

`default_nettype wire

// ===== src/lmsr_store.sv =====
// Frame store memory: one write port, two registered read ports.
`default_nettype none

module lmsr_store #(
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output logic      [7:0]    o_rdata_a,
    output logic      [7:0]    o_rdata_b
);

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/lmsr_seq.sv =====
// Command sequencer: walks the frame store one entry at a time and builds register writes.
`default_nettype none

module lmsr_seq #(
    parameter int MATRIX_COUNT       = 4,
    parameter int COLUMNS_PER_MATRIX = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire lmsr_pkg::t_cmd i_cmd,
    input  wire lmsr_pkg::t_cfg i_cfg,
    input  wire logic          i_out_free,
    output logic               o_emit,
    output lmsr_pkg::t_wr      o_word
);

    localparam int S  = MATRIX_COUNT * COLUMNS_PER_MATRIX;
    localparam int AW = (S > 1) ? $clog2(S) : 1;
    localparam int MW = (MATRIX_COUNT > 1) ? $clog2(MATRIX_COUNT) : 1;
    localparam int CW = (COLUMNS_PER_MATRIX > 1) ? $clog2(COLUMNS_PER_MATRIX) : 1;
    localparam logic [AW-1:0] LAST_IDX  = AW'(S - 1);
    localparam logic [AW-1:0] SRC_STEP  = AW'(COLUMNS_PER_MATRIX % S);
    localparam logic [AW-1:0] WRAP_FROM = AW'(S - COLUMNS_PER_MATRIX);
    localparam logic [MW-1:0] LAST_M    = MW'(MATRIX_COUNT - 1);
    localparam logic [CW-1:0] LAST_C    = CW'(COLUMNS_PER_MATRIX - 1);
    localparam bit HAS_WRAP = (MATRIX_COUNT > 1);

    lmsr_pkg::t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;   // physical place of logical entry 0
    logic [AW-1:0] r_i, n_i;         // logical index
    logic [AW-1:0] r_s, n_s;         // logical source index of the wrap bit
    logic [AW-1:0] r_pa, n_pa;       // physical address of r_i
    logic [AW-1:0] r_psrc, n_psrc;   // physical address of r_s
    logic [MW-1:0] r_m, n_m;
    logic [CW-1:0] r_c, n_c;
    logic [1:0]    r_step, n_step;
    logic          r_tops [COLUMNS_PER_MATRIX];

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [7:0]    rd_a, rd_b;
    logic          wrap_bit;

    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] v);
        return (v == LAST_IDX) ? '0 : v + AW'(1);
    endfunction

    function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= (AW + 1)'(S)) begin
            sum = sum - (AW + 1)'(S);
        end
        return sum[AW-1:0];
    endfunction

    lmsr_store #(.DEPTH(S)) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (r_pa),
        .i_raddr_b (r_psrc),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Past the wrap point the source entry is already rotated: take its saved top bit.
    assign wrap_bit = (HAS_WRAP && (r_i >= WRAP_FROM)) ? r_tops[r_s[CW-1:0]] : rd_b[7];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lmsr_pkg::ST_CLEAR;
            r_head  <= '0;
            r_i     <= '0;
            r_s     <= '0;
            r_pa    <= '0;
            r_psrc  <= '0;
            r_m     <= '0;
            r_c     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_i     <= n_i;
            r_s     <= n_s;
            r_pa    <= n_pa;
            r_psrc  <= n_psrc;
            r_m     <= n_m;
            r_c     <= n_c;
            r_step  <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lmsr_pkg::ST_ROT_WR && r_i < AW'(COLUMNS_PER_MATRIX)) begin
            r_tops[r_i[CW-1:0]] <= rd_a[7];
        end
    end

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_i     = r_i;
        n_s     = r_s;
        n_pa    = r_pa;
        n_psrc  = r_psrc;
        n_m     = r_m;
        n_c     = r_c;
        n_step  = r_step;
        we      = 1'b0;
        waddr   = r_pa;
        wdata   = lmsr_pkg::ZERO_DATA;
        o_cmd_ready = 1'b0;
        o_emit  = 1'b0;
        o_word  = '0;

        case (r_state)
            lmsr_pkg::ST_CLEAR: begin
                we = 1'b1;
                if (r_pa == LAST_IDX) begin
                    n_head  = '0;
                    n_state = lmsr_pkg::ST_IDLE;
                end else begin
                    n_pa = r_pa + AW'(1);
                end
            end

            lmsr_pkg::ST_IDLE: begin
                o_cmd_ready = 1'b1;
                n_pa = r_head;
                if (i_cmd_valid) begin
                    case (lmsr_pkg::t_op'(i_cmd.opcode))
                        lmsr_pkg::OP_CLEAR_STORE: begin
                            n_pa    = '0;
                            n_state = lmsr_pkg::ST_CLEAR;
                        end
                        lmsr_pkg::OP_PUSH: begin
                            // Oldest entry sits at the head: overwrite it, advance the head.
                            we     = 1'b1;
                            waddr  = r_head;
                            wdata  = i_cmd.push_byte;
                            n_head = inc_wrap(r_head);
                            n_pa   = inc_wrap(r_head);
                        end
                        lmsr_pkg::OP_SCROLL: begin
                            n_i     = '0;
                            n_s     = SRC_STEP;
                            n_psrc  = add_wrap(r_head, SRC_STEP);
                            n_state = lmsr_pkg::ST_ROT_RD;
                        end
                        lmsr_pkg::OP_REFRESH: begin
                            n_i     = '0;
                            n_m     = '0;
                            n_c     = '0;
                            n_state = lmsr_pkg::ST_REF_RD;
                        end
                        lmsr_pkg::OP_INIT: begin
                            n_step  = '0;
                            n_state = lmsr_pkg::ST_INIT;
                        end
                        lmsr_pkg::OP_CLEAR_DISP: begin
                            n_c     = '0;
                            n_state = lmsr_pkg::ST_CLR_DISP;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            lmsr_pkg::ST_ROT_RD: begin
                n_state = lmsr_pkg::ST_ROT_WR;
            end

            lmsr_pkg::ST_ROT_WR: begin
                we    = 1'b1;
                wdata = {rd_a[6:0], wrap_bit};
                if (r_i == LAST_IDX) begin
                    n_state = lmsr_pkg::ST_IDLE;
                end else begin
                    n_i     = r_i + AW'(1);
                    n_s     = inc_wrap(r_s);
                    n_pa    = inc_wrap(r_pa);
                    n_psrc  = inc_wrap(r_psrc);
                    n_state = lmsr_pkg::ST_ROT_RD;
                end
            end

            lmsr_pkg::ST_REF_RD: begin
                n_state = lmsr_pkg::ST_REF_EMIT;
            end

            lmsr_pkg::ST_REF_EMIT: begin
                o_word.broadcast   = 1'b0;
                o_word.device_slot = 3'(r_m);
                o_word.reg_address = 4'(r_c) + 4'd1;
                o_word.reg_data    = rd_a;
                o_word.last        = (r_i == LAST_IDX);
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (r_i == LAST_IDX) begin
                        n_state = lmsr_pkg::ST_IDLE;
                    end else begin
                        n_i  = r_i + AW'(1);
                        n_pa = inc_wrap(r_pa);
                        if (r_c == LAST_C) begin
                            n_c = '0;
                            n_m = (r_m == LAST_M) ? '0 : r_m + MW'(1);
                        end else begin
                            n_c = r_c + CW'(1);
                        end
                        n_state = lmsr_pkg::ST_REF_RD;
                    end
                end
            end

            lmsr_pkg::ST_INIT: begin
                o_word.broadcast = 1'b1;
                case (r_step)
                    2'd0: begin
                        o_word.reg_address = lmsr_pkg::ADDR_INTENSITY;
                        o_word.reg_data    = {4'd0, i_cfg.intensity_level};
                    end
                    2'd1: begin
                        o_word.reg_address = lmsr_pkg::ADDR_SCAN_LIMIT;
                        o_word.reg_data    = {5'd0, i_cfg.scan_limit};
                    end
                    default: begin
                        o_word.reg_address = lmsr_pkg::ADDR_SHUTDOWN;
                        o_word.reg_data    = lmsr_pkg::SHUTDOWN_NORMAL;
                        o_word.last        = 1'b1;
                    end
                endcase
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (r_step == 2'd2) begin
                        n_state = lmsr_pkg::ST_IDLE;
                    end else begin
                        n_step = r_step + 2'd1;
                    end
                end
            end

            lmsr_pkg::ST_CLR_DISP: begin
                o_word.broadcast   = 1'b1;
                o_word.reg_address = 4'(r_c) + 4'd1;
                o_word.reg_data    = lmsr_pkg::ZERO_DATA;
                o_word.last        = (r_c == LAST_C);
                if (i_out_free) begin
                    o_emit = 1'b1;
                    if (r_c == LAST_C) begin
                        n_pa    = '0;
                        n_state = lmsr_pkg::ST_CLEAR;
                    end else begin
                        n_c = r_c + CW'(1);
                    end
                end
            end

            default: begin
                n_state = lmsr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/led_matrix_scroll_refresh.sv =====
// Top level: LED matrix chain frame store with scroll, refresh and init sequencing.
// Push: one entry. Clear store: zeroes S entries (S = MATRIX_COUNT*COLUMNS_PER_MATRIX).
// Scroll: the accept step, then a read and then a write per entry.
// Refresh: a read, then an emit per word (S words), held by a full output; init 3 words;
// clear display C words, then a store clear. Reset (synchronous, active low) runs a clearing
// pass; no command is taken until it ends, config writes at once. Output is registered.
`default_nettype none

module led_matrix_scroll_refresh #(
    parameter int MATRIX_COUNT       = 4,
    parameter int COLUMNS_PER_MATRIX = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // command channel
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire lmsr_pkg::t_cmd i_in,
    // register write channel
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output lmsr_pkg::t_wr       o_out,
    // configuration write port
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_index,
    input  wire logic [3:0]     i_cfg_data
);

    lmsr_pkg::t_cfg r_cfg;
    logic           r_out_valid;
    lmsr_pkg::t_wr  r_out;
    logic           out_free;
    logic           emit;
    lmsr_pkg::t_wr  word;

    // Config registers; an index beyond the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.intensity_level <= 4'd7;
            r_cfg.scan_limit      <= 3'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                lmsr_pkg::CFG_INTENSITY:  r_cfg.intensity_level <= i_cfg_data;
                lmsr_pkg::CFG_SCAN_LIMIT: r_cfg.scan_limit      <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    // Output slot is free when empty or being taken this cycle.
    assign out_free = !r_out_valid || i_out_ready;

    lmsr_seq #(
        .MATRIX_COUNT       (MATRIX_COUNT),
        .COLUMNS_PER_MATRIX (COLUMNS_PER_MATRIX)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .o_cmd_ready (o_in_ready),
        .i_cmd       (i_in),
        .i_cfg       (r_cfg),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_word      (word)
    );

    // Hold the word until taken; load a new one when the slot frees.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
